/* sv/rcd_pkg.sv */
// Package for the chunk header decoder: status codes, field widths, command/status structs.
// No dependencies.
`timescale 1ns / 1ps
package rcd_pkg;
    localparam int WIN_BYTES = 18;
    localparam logic [23:0] TS_ESCAPE = 24'hFFFFFF;
    localparam logic [7:0] CSID_MASK = 8'h3F;
    localparam logic [16:0] CSID_BASE = 17'd64;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ID   = 2'd1,
        ST_NO_PRIOR = 2'd2,
        ST_BAD_TYPE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_MIN_ID   = 2'd0,
        CFG_ID_LIMIT = 2'd1,
        CFG_TYPE_LIM = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic load;     // capture input window, decode basic header
        logic search;   // step table search one entry
        logic finish;   // build result and write table
    } ctrl_cmd_t;

    typedef struct packed {
        logic early_err;   // basic header / id error known after load
        logic search_done;
    } dp_status_t;
endpackage

/* sv/rcd_if.sv */
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface rcd_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/rcd_ctrl.sv */
// Controller FSM for the chunk header decoder.
// Depends on rcd_pkg.
`timescale 1ns / 1ps
module rcd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output rcd_pkg::ctrl_cmd_t cmd,
    input  rcd_pkg::dp_status_t stat
);
    import rcd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_FINISH = 4'b0100,
        S_OUT    = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (stat.early_err || stat.search_done)
                    state_next = S_FINISH;
                else
                    cmd.search = 1'b1;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

/* sv/rcd_datapath.sv */
// Datapath: window decode, per-stream table with serial key search, result register.
// Depends on rcd_pkg.
`timescale 1ns / 1ps
module rcd_datapath #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rcd_pkg::ctrl_cmd_t  cmd,
    output rcd_pkg::dp_status_t stat,
    input  logic [63:0]         head_bytes,
    input  logic [63:0]         mid_bytes,
    input  logic [15:0]         tail_bytes,
    input  logic [4:0]          avail_len,
    input  logic [16:0]         min_stream_id,
    input  logic [16:0]         stream_id_limit,
    input  logic [8:0]          type_id_limit,
    output logic [1:0]          status,
    output logic [4:0]          header_len,
    output logic [1:0]          chunk_fmt,
    output logic [16:0]         chunk_stream,
    output logic [31:0]         abs_timestamp,
    output logic [23:0]         msg_length,
    output logic [7:0]          msg_type,
    output logic [31:0]         msg_stream,
    output logic                table_full
);
    import rcd_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [7:0] win_reg [WIN_BYTES];
    logic [4:0] avail_reg;
    logic [4:0] pos_reg;
    logic [1:0] fmt_reg;
    logic [16:0] cid_reg;
    logic        err_reg;

    logic [16:0] key_reg [TABLE_DEPTH];
    logic [31:0] ets_reg [TABLE_DEPTH];
    logic [23:0] elen_reg [TABLE_DEPTH];
    logic [7:0]  etyp_reg [TABLE_DEPTH];
    logic [31:0] estr_reg [TABLE_DEPTH];

    logic [CW-1:0] scan_reg;
    logic          hit_reg, free_ok_reg;
    logic [IW-1:0] hit_idx_reg, free_idx_reg;

    // basic header decode from input
    logic [7:0]  b0, b1, b2;
    logic [4:0]  av;
    logic [1:0]  fmt_d;
    logic [16:0] cid_d;
    logic [4:0]  pos_d;
    logic        err_d;

    always_comb
    begin
        b0 = head_bytes[63:56];
        b1 = head_bytes[55:48];
        b2 = head_bytes[47:40];
        av = (avail_len > 5'(WIN_BYTES)) ? 5'(WIN_BYTES) : avail_len;
        fmt_d = b0[7:6];
        err_d = 1'b0;
        case (b0 & CSID_MASK)
            8'd0:
            begin
                cid_d = CSID_BASE + {9'd0, b1};
                pos_d = 5'd2;
                if (av < 5'd2) err_d = 1'b1;
            end
            8'd1:
            begin
                cid_d = CSID_BASE + {9'd0, b1} + {1'b0, b2, 8'd0};
                pos_d = 5'd3;
                if (av < 5'd3) err_d = 1'b1;
            end
            default:
            begin
                cid_d = {11'd0, b0[5:0]};
                pos_d = 5'd1;
            end
        endcase
        if (av == 5'd0) err_d = 1'b1;
        if (cid_d < min_stream_id || cid_d >= stream_id_limit) err_d = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < 8; i++)
            begin
                win_reg[i]     <= head_bytes[63-8*i -: 8];
                win_reg[8 + i] <= mid_bytes[63-8*i -: 8];
            end
            win_reg[16] <= tail_bytes[15:8];
            win_reg[17] <= tail_bytes[7:0];
            avail_reg <= av;
            pos_reg <= pos_d;
            fmt_reg <= fmt_d;
            cid_reg <= cid_d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg <= 1'b0;
            scan_reg <= '0;
            hit_reg <= 1'b0;
            free_ok_reg <= 1'b0;
            hit_idx_reg <= '0;
            free_idx_reg <= '0;
        end
        else if (cmd.load)
        begin
            err_reg <= err_d;
            scan_reg <= '0;
            hit_reg <= 1'b0;
            free_ok_reg <= 1'b0;
        end
        else if (cmd.search)
        begin
            // one entry a cycle; first match / first free wins
            if (!hit_reg && key_reg[scan_reg[IW-1:0]] == cid_reg)
            begin
                hit_reg <= 1'b1;
                hit_idx_reg <= scan_reg[IW-1:0];
            end
            if (!free_ok_reg && key_reg[scan_reg[IW-1:0]] == 17'd0)
            begin
                free_ok_reg <= 1'b1;
                free_idx_reg <= scan_reg[IW-1:0];
            end
            scan_reg <= scan_reg + 1'b1;
        end
    end

    assign stat.early_err = err_reg;
    assign stat.search_done = hit_reg || (scan_reg == CW'(TABLE_DEPTH));

    // message header decode from stored window
    function automatic logic [7:0] wb(input logic [7:0] w [WIN_BYTES], input logic [5:0] p);
        logic [5:0] q;
        q = (p >= 6'(WIN_BYTES)) ? p - 6'(WIN_BYTES) : p;
        return w[q[4:0]];
    endfunction

    logic [31:0] p_ts, p_str, ts, mstr, ts4;
    logic [23:0] p_len, len, ts3;
    logic [7:0]  p_typ, typ;
    logic [5:0]  pos;
    logic [1:0]  st;
    logic        store;

    always_comb
    begin
        p_ts = hit_reg ? ets_reg[hit_idx_reg] : '0;
        p_len = hit_reg ? elen_reg[hit_idx_reg] : '0;
        p_typ = hit_reg ? etyp_reg[hit_idx_reg] : '0;
        p_str = hit_reg ? estr_reg[hit_idx_reg] : '0;
        pos = {1'b0, pos_reg};
        ts3 = '0; len = '0; typ = '0; mstr = '0;
        if (fmt_reg <= 2'd2)
        begin
            ts3 = {wb(win_reg, pos), wb(win_reg, pos + 6'd1), wb(win_reg, pos + 6'd2)};
            pos = pos + 6'd3;
        end
        if (fmt_reg <= 2'd1)
        begin
            len = {wb(win_reg, pos), wb(win_reg, pos + 6'd1), wb(win_reg, pos + 6'd2)};
            typ = wb(win_reg, pos + 6'd3);
            pos = pos + 6'd4;
        end
        if (fmt_reg == 2'd0)
        begin
            mstr = {wb(win_reg, pos + 6'd3), wb(win_reg, pos + 6'd2),
                    wb(win_reg, pos + 6'd1), wb(win_reg, pos)};
            pos = pos + 6'd4;
        end
        if (mstr == '0) mstr = p_str;
        if (len == '0) len = p_len;
        if (typ == '0) typ = p_typ;
        ts = {8'd0, ts3};
        ts4 = {wb(win_reg, pos), wb(win_reg, pos + 6'd1),
               wb(win_reg, pos + 6'd2), wb(win_reg, pos + 6'd3)};
        if (ts3 == TS_ESCAPE)
        begin
            if (pos + 6'd4 <= {1'b0, avail_reg})
            begin
                ts = ts4;
                pos = pos + 6'd4;
            end
        end
        else if (fmt_reg == 2'd3)
        begin
            if (pos + 6'd4 <= {1'b0, avail_reg} && p_ts != '0 && ts4 == p_ts)
                pos = pos + 6'd4;
        end
        if (fmt_reg != 2'd0)
            ts = ts + p_ts;
        store = 1'b0;
        if (err_reg)
            st = ST_BAD_ID;
        else if (!hit_reg && fmt_reg != 2'd0)
            st = ST_NO_PRIOR;
        else if ({1'b0, typ} >= type_id_limit)
            st = ST_BAD_TYPE;
        else
        begin
            st = ST_OK;
            store = hit_reg || free_ok_reg;
        end
    end

    logic [IW-1:0] wr_idx;
    assign wr_idx = hit_reg ? hit_idx_reg : free_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                key_reg[i] <= '0;
        end
        else if (cmd.finish && store)
            key_reg[wr_idx] <= cid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish && store)
        begin
            ets_reg[wr_idx] <= ts;
            elen_reg[wr_idx] <= len;
            etyp_reg[wr_idx] <= typ;
            estr_reg[wr_idx] <= mstr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status <= st;
            if (st == ST_OK)
            begin
                header_len <= pos[4:0];
                chunk_fmt <= fmt_reg;
                chunk_stream <= cid_reg;
                abs_timestamp <= ts;
                msg_length <= len;
                msg_type <= typ;
                msg_stream <= mstr;
                table_full <= !store;
            end
            else
            begin
                header_len <= '0;
                chunk_fmt <= '0;
                chunk_stream <= '0;
                abs_timestamp <= '0;
                msg_length <= '0;
                msg_type <= '0;
                msg_stream <= '0;
                table_full <= 1'b0;
            end
        end
    end
endmodule

/* sv/rtmp_chunk_header_decoder.sv */
// Chunk header decoder, top level: config registers, controller, datapath.
// Each item passes the states idle (load), search (stops at the first key match or after
// TABLE_DEPTH entries), finish and out; a new item is taken only back in idle.
// The result is held in the output register until taken; input is refused meanwhile.
// Reset clears the table keys, the controller and loads register defaults.
`timescale 1ns / 1ps
module rtmp_chunk_header_decoder #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    rcd_if.sink         in_ch,
    rcd_if.source       out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    import rcd_pkg::*;

    logic [16:0] min_id_reg, id_lim_reg;
    logic [8:0]  type_lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_id_reg <= 17'd2;
            id_lim_reg <= 17'd65600;
            type_lim_reg <= 9'd23;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_ID:   min_id_reg <= cfg_data;
                CFG_ID_LIMIT: id_lim_reg <= cfg_data;
                CFG_TYPE_LIM: type_lim_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    rcd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .cmd(cmd), .stat(stat)
    );

    // input payload {head, mid, tail, avail}; output {status .. table_full}
    rcd_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .head_bytes(in_ch.data[148:85]),
        .mid_bytes(in_ch.data[84:21]),
        .tail_bytes(in_ch.data[20:5]),
        .avail_len(in_ch.data[4:0]),
        .min_stream_id(min_id_reg),
        .stream_id_limit(id_lim_reg),
        .type_id_limit(type_lim_reg),
        .status(out_ch.data[122:121]),
        .header_len(out_ch.data[120:116]),
        .chunk_fmt(out_ch.data[115:114]),
        .chunk_stream(out_ch.data[113:97]),
        .abs_timestamp(out_ch.data[96:65]),
        .msg_length(out_ch.data[64:41]),
        .msg_type(out_ch.data[40:33]),
        .msg_stream(out_ch.data[32:1]),
        .table_full(out_ch.data[0])
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid)) else $error("input taken while result pending");
    a_err_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.data[122:121] != 2'd0 |-> out_ch.data[120:116] == 5'd0)
        else $error("error result with nonzero length");
    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready) else $error("second item accepted");
endmodule

/* tb/rtmp_chunk_header_decoder_test.sv */
// Testbench for rtmp_chunk_header_decoder: directed and random chunk headers, with a
// local header-table predictor checked against every result item.
// Depends on rcd_pkg, rcd_if and the decoder RTL.
`timescale 1ns / 1ps
module rtmp_chunk_header_decoder_test;
    import rcd_pkg::*;

    typedef struct packed {
        logic [63:0] head;
        logic [63:0] mid;
        logic [15:0] tail;
        logic [4:0]  avail;
    } window_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  header_len;
        logic [1:0]  fmt;
        logic [16:0] stream;
        logic [31:0] ts;
        logic [23:0] len;
        logic [7:0]  typ;
        logic [31:0] mstr;
        logic        full;
    } header_t;

    localparam int DEPTH = 16;
    localparam int TABLE_DEPTH_CYCLES = DEPTH + 8;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;

    rcd_if #(.W($bits(window_t))) in_ch ();
    rcd_if #(.W($bits(header_t))) out_ch ();

    rtmp_chunk_header_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [16:0] key_tab [DEPTH];
    logic [31:0] ts_tab  [DEPTH];
    logic [23:0] len_tab [DEPTH];
    logic [7:0]  typ_tab [DEPTH];
    logic [31:0] str_tab [DEPTH];
    int unsigned min_id, id_limit, type_limit;
    logic [7:0]  win [18];

    window_t pending_items [$];
    header_t expected_headers [$];
    int      errors;
    bit      quiet;
    bit      long_stall_req, long_stall_seen;

    always #6 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("rtmp_chunk_header_decoder test failed");
        $finish;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int find_stream(input logic [16:0] key);
        for (int i = 0; i < DEPTH; i++)
            if (key_tab[i] == key)
                return i;
        return -1;
    endfunction

    function automatic logic [31:0] win_read(input int pos, input int n);
        logic [31:0] v;
        v = 0;
        for (int i = 0; i < n; i++)
            v = (v << 8) | win[(pos + i) % 18];
        return v;
    endfunction

    function automatic header_t decode_header(input window_t x);
        header_t     r;
        int          av, pos, idx;
        logic [1:0]  fmt;
        logic [16:0] cid;
        logic [31:0] ts, len, typ, mstr, pts, plen, ptyp, pstr;
        r = '0;
        pts = 0; plen = 0; ptyp = 0; pstr = 0;
        for (int i = 0; i < 8; i++)
        begin
            win[i] = x.head[63 - 8 * i -: 8];
            win[8 + i] = x.mid[63 - 8 * i -: 8];
        end
        win[16] = x.tail[15:8];
        win[17] = x.tail[7:0];
        av = (x.avail > 18) ? 18 : x.avail;
        r.status = ST_BAD_ID;
        if (av == 0)
            return r;
        fmt = win[0][7:6];
        cid = win[0] & CSID_MASK;
        if (cid == 0)
        begin
            if (av < 2)
                return r;
            cid = CSID_BASE + win[1];
            pos = 2;
        end
        else if (cid == 1)
        begin
            if (av < 3)
                return r;
            cid = CSID_BASE + win[1] + (17'(win[2]) << 8);
            pos = 3;
        end
        else
            pos = 1;
        if (cid < min_id || cid >= id_limit)
            return r;
        idx = find_stream(cid);
        if (idx >= 0)
        begin
            pts = ts_tab[idx]; plen = len_tab[idx]; ptyp = typ_tab[idx]; pstr = str_tab[idx];
        end
        else if (fmt != 0)
        begin
            r.status = ST_NO_PRIOR;
            return r;
        end
        ts = 0; len = 0; typ = 0; mstr = 0;
        if (fmt <= 2)
        begin
            ts = win_read(pos, 3);
            pos += 3;
        end
        if (fmt <= 1)
        begin
            len = win_read(pos, 3);
            typ = win[(pos + 3) % 18];
            pos += 4;
        end
        if (fmt == 0)
        begin
            mstr = {win[(pos + 3) % 18], win[(pos + 2) % 18], win[(pos + 1) % 18], win[pos % 18]};
            pos += 4;
        end
        if (mstr == 0) mstr = pstr;
        if (len == 0) len = plen;
        if (typ == 0) typ = ptyp;
        if (ts == {8'h00, TS_ESCAPE})
        begin
            if (pos + 4 <= av)
            begin
                ts = win_read(pos, 4);
                pos += 4;
            end
        end
        else if (fmt == 3)
        begin
            if (pos + 4 <= av && pts != 0 && win_read(pos, 4) == pts)
                pos += 4;
        end
        if (fmt != 0)
            ts = ts + pts;
        if (typ >= type_limit)
        begin
            r.status = ST_BAD_TYPE;
            return r;
        end
        if (idx < 0)
            idx = find_stream(0);
        if (idx >= 0)
        begin
            key_tab[idx] = cid; ts_tab[idx] = ts; len_tab[idx] = 24'(len);
            typ_tab[idx] = 8'(typ); str_tab[idx] = mstr;
        end
        else
            r.full = 1'b1;
        r.status = ST_OK;
        r.header_len = 5'(pos);
        r.fmt = fmt;
        r.stream = cid;
        r.ts = ts;
        r.len = 24'(len);
        r.typ = 8'(typ);
        r.mstr = mstr;
        return r;
    endfunction

    // Builds a header; three_byte forces the 3-byte basic header, rep_ts is put after it.
    function automatic window_t build_header(input logic [1:0] fmt, input logic [16:0] cid,
            input bit three_byte, input logic [23:0] ts, input logic [23:0] len,
            input logic [7:0] typ, input logic [31:0] mstr, input logic [31:0] rep_ts,
            input logic [4:0] avail);
        logic [7:0]  b [18];
        int          p;
        logic [16:0] off;
        window_t     x;
        for (int i = 0; i < 18; i++)
            b[i] = 8'($urandom);
        off = cid - 17'd64;
        if (!three_byte && cid >= 2 && cid < 64)
        begin
            b[0] = {fmt, cid[5:0]};
            p = 1;
        end
        else if (!three_byte && cid < 320)
        begin
            b[0] = {fmt, 6'd0}; b[1] = off[7:0];
            p = 2;
        end
        else
        begin
            b[0] = {fmt, 6'd1}; b[1] = off[7:0]; b[2] = off[15:8];
            p = 3;
        end
        if (fmt <= 2)
        begin
            b[p] = ts[23:16]; b[p + 1] = ts[15:8]; b[p + 2] = ts[7:0];
            p += 3;
        end
        if (fmt <= 1)
        begin
            b[p] = len[23:16]; b[p + 1] = len[15:8]; b[p + 2] = len[7:0]; b[p + 3] = typ;
            p += 4;
        end
        if (fmt == 0)
        begin
            b[p] = mstr[7:0]; b[p + 1] = mstr[15:8]; b[p + 2] = mstr[23:16]; b[p + 3] = mstr[31:24];
            p += 4;
        end
        b[p] = rep_ts[31:24]; b[p + 1] = rep_ts[23:16]; b[p + 2] = rep_ts[15:8]; b[p + 3] = rep_ts[7:0];
        for (int i = 0; i < 8; i++)
        begin
            x.head[63 - 8 * i -: 8] = b[i];
            x.mid[63 - 8 * i -: 8] = b[8 + i];
        end
        x.tail = {b[16], b[17]};
        x.avail = avail;
        return x;
    endfunction

    function automatic window_t random_header();
        logic [1:0]  fmt;
        logic [16:0] cid;
        logic [23:0] ts;
        logic [31:0] rep;
        logic [4:0]  avail;
        int          k, idx;
        window_t     x;
        k = $urandom_range(0, 99);
        if (k < 8)
        begin
            x.head = {$urandom, $urandom};
            x.mid = {$urandom, $urandom};
            x.tail = 16'($urandom);
            x.avail = 5'($urandom);
            return x;
        end
        fmt = 2'($urandom_range(0, 3));
        k = $urandom_range(0, 99);
        if (k < 55)       cid = 17'($urandom_range(2, 12));
        else if (k < 75)  cid = 17'($urandom_range(64, 70));
        else if (k < 85)  cid = 17'($urandom_range(65590, 65599));
        else              cid = 17'($urandom_range(2, 65599));
        ts = ($urandom_range(0, 9) == 0) ? TS_ESCAPE : 24'($urandom);
        idx = find_stream(cid);
        rep = $urandom;
        if (idx >= 0 && $urandom_range(0, 1))
            rep = ts_tab[idx];
        avail = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) : 5'd18;
        return build_header(fmt, cid, $urandom_range(0, 5) == 0, ts,
            ($urandom_range(0, 5) == 0) ? 24'd0 : 24'($urandom),
            ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 30)),
            ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom, rep, avail);
    endfunction

    // sender
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        logic next_valid;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                expected_headers.push_back(decode_header(window_t'(in_ch.data)));
            if (!(in_ch.valid && !in_ch.ready))
            begin
                next_valid = 1'b0;
                if (send_gap > 0)
                    send_gap--;
                else if (!quiet && $urandom_range(0, 19) == 0)
                    send_gap = $urandom_range(1, 17) - 1;
                else if (pending_items.size() > 0)
                begin
                    in_ch.data <= pending_items.pop_front();
                    next_valid = 1'b1;
                end
                in_ch.valid <= next_valid;
            end
        end
    end

    // receiver
    int recv_gap;
    always @(posedge clk or negedge rst_n)
    begin
        header_t got, want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = header_t'(out_ch.data);
                if (expected_headers.size() == 0)
                    report("unexpected item", 64'(got), 0);
                else
                begin
                    want = expected_headers.pop_front();
                    if (got.status != want.status) report("status", got.status, want.status);
                    if (got.header_len != want.header_len)
                        report("header_len", got.header_len, want.header_len);
                    if (got.fmt != want.fmt) report("chunk_fmt", got.fmt, want.fmt);
                    if (got.stream != want.stream) report("chunk_stream", got.stream, want.stream);
                    if (got.ts != want.ts) report("abs_timestamp", got.ts, want.ts);
                    if (got.len != want.len) report("msg_length", got.len, want.len);
                    if (got.typ != want.typ) report("msg_type", got.typ, want.typ);
                    if (got.mstr != want.mstr) report("msg_stream", got.mstr, want.mstr);
                    if (got.full != want.full) report("table_full", got.full, want.full);
                end
            end
            if (long_stall_req && !long_stall_seen)
            begin
                long_stall_seen = 1;
                recv_gap = 300;
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 15) == 0)
            begin
                recv_gap = $urandom_range(1, 17) - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic drain();
        while (pending_items.size() > 0 || in_ch.valid || expected_headers.size() > 0)
            @(posedge clk);
        repeat (TABLE_DEPTH_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 17'(value);
        case (idx)
            CFG_MIN_ID:   min_id = value;
            CFG_ID_LIMIT: id_limit = value;
            default:      type_limit = value;
        endcase
    endtask

    task automatic set_limits(input int unsigned lo, input int unsigned hi, input int unsigned tl);
        write_reg(CFG_MIN_ID, lo);
        write_reg(CFG_ID_LIMIT, hi);
        write_reg(CFG_TYPE_LIM, tl);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic feed(input window_t x);
        while (pending_items.size() > 1)
            @(posedge clk);
        pending_items.push_back(x);
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            while (pending_items.size() > 1)
                @(posedge clk);
            pending_items.push_back(random_header());
        end
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = CFG_MIN_ID;
        cfg_data = '0;
        errors = 0;
        min_id = 2; id_limit = 65600; type_limit = 23;
        for (int i = 0; i < DEPTH; i++)
        begin
            key_tab[i] = 0; ts_tab[i] = 0; len_tab[i] = 0; typ_tab[i] = 0; str_tab[i] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty window, short basic headers, each fmt, escapes, repeats, bad type
        feed(build_header(2'd0, 17'd5, 0, 24'd100, 24'd300, 8'd9, 32'd1, 0, 5'd0));
        feed(build_header(2'd0, 17'd70, 0, 24'd1, 24'd1, 8'd1, 32'd1, 0, 5'd1));
        feed(build_header(2'd0, 17'd70, 1, 24'd1, 24'd1, 8'd1, 32'd1, 0, 5'd2));
        feed(build_header(2'd1, 17'd40, 0, 24'd1, 24'd1, 8'd1, 32'd1, 0, 5'd18));
        feed(build_header(2'd0, 17'd5, 0, 24'hFFFFFE, 24'hFFFFFF, 8'd22, 32'hFFFFFFFF, 0, 5'd18));
        feed(build_header(2'd1, 17'd5, 0, 24'd10, 24'd0, 8'd0, 0, 0, 5'd18));
        feed(build_header(2'd2, 17'd5, 0, 24'd0, 0, 0, 0, 0, 5'd31));
        feed(build_header(2'd3, 17'd5, 0, 0, 0, 0, 0, 32'd0, 5'd18));
        feed(build_header(2'd0, 17'd6, 0, TS_ESCAPE, 24'd5, 8'd8, 32'd7, 32'h12345678, 5'd18));
        feed(build_header(2'd0, 17'd7, 0, TS_ESCAPE, 24'd5, 8'd8, 32'd7, 32'h1, 5'd14));
        feed(build_header(2'd3, 17'd6, 0, 0, 0, 0, 0, 32'h12345678, 5'd18));
        feed(build_header(2'd3, 17'd6, 0, 0, 0, 0, 0, 32'h12345678, 5'd4));
        feed(build_header(2'd2, 17'd6, 0, TS_ESCAPE, 0, 0, 0, 32'hFFFFFFFF, 5'd18));
        feed(build_header(2'd0, 17'd65599, 1, 24'd3, 24'd3, 8'd23, 32'd3, 0, 5'd18));
        feed(build_header(2'd0, 17'd65599, 1, 24'd3, 24'd3, 8'd3, 32'd3, 0, 5'd18));
        feed(build_header(2'd0, 17'd319, 0, 24'd0, 24'd0, 8'd0, 32'd0, 0, 5'd18));
        feed(build_header(2'd0, 17'd64, 0, 24'd4, 24'd4, 8'd4, 32'd4, 0, 5'd3));
        feed({64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 16'hFFFF, 5'd31});
        feed({64'h0, 64'h0, 16'h0, 5'd18});
        drain();

        set_limits(0, 65600, 256);
        run_random(330);
        // receiver stalls long while items keep coming
        long_stall_req = 1;
        run_random(300);
        drain();

        set_limits(65599, 65600, 1);
        run_random(40);
        drain();
        set_limits(3, 1, 23);
        run_random(30);
        drain();
        set_limits(4, 300, 40);
        run_random(250);
        // sender pause until everything is back
        while (pending_items.size() > 0 || in_ch.valid || expected_headers.size() > 0)
            @(posedge clk);
        run_random(100);
        drain();

        set_limits(2, 65600, 23);
        quiet = 1;
        run_random(250);
        drain();

        if (errors == 0)
            $display("rtmp_chunk_header_decoder test passed");
        else
            $display("rtmp_chunk_header_decoder test failed");
        $finish;
    end
endmodule

/* files.f */
sv/rcd_pkg.sv
sv/rcd_if.sv
sv/rcd_ctrl.sv
sv/rcd_datapath.sv
sv/rtmp_chunk_header_decoder.sv
tb/rtmp_chunk_header_decoder_test.sv
